FILE: hw/rtl/mlprr_pkg.sv
// ----------------------------------------------------------------------------
// mlprr_pkg
// Shared types, codes and default sizes for the multilevel priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlprr_pkg;

   // Default sizes
   localparam int DEF_MAX_TASKS    = 16;
   localparam int DEF_MAX_LEVELS   = 3;
   localparam int DEF_TASK_ID_BITS = 8;

   // Configuration register
   localparam logic [1:0] NUM_LEVELS_RESET = 2'd3;
   localparam int         CSR_ADDR_BITS    = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_NUM_LEVELS = 3'd0;

   // Event codes
   localparam logic [1:0] ACT_ENQ    = 2'd0;
   localparam logic [1:0] ACT_TICK   = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;

   // Result status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_BAD_PRIO = 2'd1;
   localparam logic [1:0] STS_FULL     = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PASS,
      ST_UNLINK,
      ST_APPEND,
      ST_SINIT,
      ST_SEARCH,
      ST_FIN,
      ST_OUT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic enq;
      logic append;
      logic pass;
      logic unlink_init;
      logic unlink_do;
      logic step;
      logic search_init;
      logic fin_init;
      logic next_level;
      logic select;
      logic mark;
      logic out_write;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [1:0] act;
      logic       prio_bad;
      logic       full;
      logic       preempt;
      logic       run_valid;
      logic       hit;
      logic       p_end;
      logic       p_match;
      logic       p_task_match;
      logic       p_done;
      logic       lv_last;
      logic       out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/mlprr_if.sv
// ----------------------------------------------------------------------------
// mlprr_if
// Valid/ready channels for scheduler events and scheduler results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlprr_req_if #(parameter int TASK_ID_BITS = 8);
   logic                    valid;
   logic                    ready;
   logic [1:0]              action;
   logic [TASK_ID_BITS-1:0] task_id;
   logic signed [3:0]       priority_req;

   modport source (output valid, action, task_id, priority_req, input ready);
   modport sink   (input valid, action, task_id, priority_req, output ready);
endinterface

interface mlprr_rsp_if #(parameter int TASK_ID_BITS = 8);
   logic                    valid;
   logic                    ready;
   logic                    running_valid;
   logic [TASK_ID_BITS-1:0] running_task;
   logic                    switched;
   logic [1:0]              status;

   modport source (output valid, running_valid, running_task, switched, status,
                   input ready);
   modport sink   (input valid, running_valid, running_task, switched, status,
                   output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mlprr_ctrl.sv
// ----------------------------------------------------------------------------
// mlprr_ctrl
// Sequencer: decodes one event and steps the datapath through list walks.
// ----------------------------------------------------------------------------
`default_nettype none

module mlprr_ctrl
   import mlprr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire dp_stat_type  stat,
   output      ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (stat.act)
               ACT_ENQ: begin
                  if (!stat.prio_bad && !stat.full && stat.preempt) state_in = ST_PASS;
                  else state_in = ST_OUT;
               end
               ACT_TICK:   state_in = ST_PASS;
               ACT_FINISH: state_in = ST_FIN;
               default:    state_in = ST_OUT;
            endcase
         end
         ST_PASS: begin
            state_in = stat.run_valid ? ST_UNLINK : ST_SINIT;
         end
         ST_UNLINK: begin
            if (stat.p_end || stat.p_match) state_in = ST_APPEND;
         end
         ST_APPEND: state_in = ST_SINIT;
         ST_SINIT:  state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (stat.p_end) begin
               if (stat.lv_last) state_in = ST_OUT;
            end else if (!stat.p_done) begin
               state_in = ST_OUT;
            end
         end
         ST_FIN: begin
            if ((stat.p_end || stat.p_task_match) && stat.lv_last) begin
               state_in = stat.hit ? ST_PASS : ST_OUT;
            end
         end
         ST_OUT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.act == ACT_ENQ && !stat.prio_bad && !stat.full) begin
               cmd.enq    = 1'b1;
               cmd.append = 1'b1;
            end
            if (stat.act == ACT_FINISH) cmd.fin_init = 1'b1;
         end
         ST_PASS: begin
            cmd.pass        = 1'b1;
            cmd.unlink_init = stat.run_valid;
         end
         ST_UNLINK: begin
            if (!stat.p_end) begin
               if (stat.p_match) cmd.unlink_do = 1'b1;
               else cmd.step = 1'b1;
            end
         end
         ST_APPEND: cmd.append = 1'b1;
         ST_SINIT:  cmd.search_init = 1'b1;
         ST_SEARCH: begin
            if (stat.p_end) begin
               cmd.next_level = !stat.lv_last;
            end else if (!stat.p_done) begin
               cmd.select = 1'b1;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FIN: begin
            if (!stat.p_end && stat.p_task_match) cmd.mark = 1'b1;
            if (stat.p_end || stat.p_task_match) cmd.next_level = !stat.lv_last;
            else cmd.step = 1'b1;
         end
         ST_OUT: cmd.out_write = stat.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mlprr_dp.sv
// ----------------------------------------------------------------------------
// mlprr_dp
// Task store, per-level linked lists, walk pointers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlprr_dp
   import mlprr_pkg::*;
#(
   parameter int MAX_TASKS    = DEF_MAX_TASKS,
   parameter int MAX_LEVELS   = DEF_MAX_LEVELS,
   parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctrl_cmd_type            cmd,
   output      dp_stat_type             stat,
   input  wire logic [1:0]              req_action,
   input  wire logic [TASK_ID_BITS-1:0] req_task_id,
   input  wire logic [3:0]              req_priority,
   input  wire logic [$clog2(MAX_LEVELS+1)-1:0] n_levels,
   input  wire logic                    rsp_ready,
   output      logic                    rsp_valid,
   output      logic                    rsp_running_valid,
   output      logic [TASK_ID_BITS-1:0] rsp_running_task,
   output      logic                    rsp_switched,
   output      logic [1:0]              rsp_status
);

   localparam int PW = $clog2(MAX_TASKS + 1);
   localparam int IW = $clog2(MAX_TASKS);
   localparam int LW = $clog2(MAX_LEVELS);
   localparam int NW = $clog2(MAX_LEVELS + 1);
   localparam int CW = NW + 1;
   localparam logic [PW-1:0] NIL = PW'(MAX_TASKS);

   // Task store
   logic [TASK_ID_BITS-1:0] task_ff  [MAX_TASKS];
   logic [PW-1:0]           next_ff  [MAX_TASKS];
   logic [LW-1:0]           level_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0]    done_ff;

   // Lists and scheduler state
   logic [PW-1:0] head_ff [MAX_LEVELS];
   logic [PW-1:0] tail_ff [MAX_LEVELS];
   logic [PW-1:0] run_ff;
   logic [TASK_ID_BITS-1:0] run_task_ff;
   logic [LW-1:0] run_lv_ff;
   logic [PW-1:0] used_ff;

   // Event and walk registers
   logic [1:0]              act_ff;
   logic [TASK_ID_BITS-1:0] tid_ff;
   logic [3:0]              prio_ff;
   logic                    hit_ff;
   logic [PW-1:0]           p_ff, prev_ff, steps_ff;
   logic [LW-1:0]           lv_ff;
   logic [1:0]              status_ff;
   logic                    switched_ff;

   logic signed [4:0] prio_s, n_s;
   logic [LW-1:0]     new_lv, ap_lv, lv_nx;
   logic [IW-1:0]     ap_e, p_idx, e_idx;
   logic              prio_bad, full, run_valid;

   assign prio_s    = 5'(signed'(prio_ff));
   assign n_s       = signed'(5'(n_levels));
   assign prio_bad  = (prio_s > 5'sd1) || (prio_s <= 5'sd1 - n_s);
   assign new_lv    = LW'(5'sd1 - prio_s);
   assign full      = (used_ff == NIL);
   assign run_valid = (run_ff != NIL);
   assign p_idx     = p_ff[IW-1:0];
   assign e_idx     = used_ff[IW-1:0];
   assign lv_nx     = lv_ff + 1'b1;

   // Pick the entry to append: a new task or the rotated running task
   assign ap_lv = cmd.enq ? new_lv : run_lv_ff;
   assign ap_e  = cmd.enq ? e_idx : run_ff[IW-1:0];

   always_comb begin
      stat              = '0;
      stat.act          = act_ff;
      stat.prio_bad     = prio_bad;
      stat.full         = full;
      stat.preempt      = run_valid && (run_lv_ff > new_lv);
      stat.run_valid    = run_valid;
      stat.hit          = hit_ff;
      stat.p_end        = (p_ff == NIL) || (steps_ff == NIL);
      stat.p_match      = (p_ff == run_ff);
      stat.p_task_match = (task_ff[p_idx] == tid_ff);
      stat.p_done       = done_ff[p_idx];
      stat.lv_last      = (CW'(lv_ff) + 1'b1) >= CW'(n_levels);
      stat.out_free     = !rsp_valid || rsp_ready;
   end

   // Latch event fields
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req_action;
         tid_ff  <= req_task_id;
         prio_ff <= req_priority;
      end
   end

   // Store payload writes
   always_ff @(posedge clock) begin
      if (cmd.enq) begin
         task_ff[e_idx]  <= tid_ff;
         level_ff[e_idx] <= new_lv;
      end
      if (cmd.unlink_do && prev_ff != NIL) begin
         next_ff[prev_ff[IW-1:0]] <= next_ff[p_idx];
      end
      if (cmd.append) begin
         next_ff[ap_e] <= NIL;
         if (head_ff[ap_lv] != NIL && tail_ff[ap_lv] != NIL) begin
            next_ff[tail_ff[ap_lv][IW-1:0]] <= PW'(ap_e);
         end
      end
   end

   // Control state: lists, running entry, done bits, entry count, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
         end
         done_ff     <= '0;
         run_ff      <= NIL;
         used_ff     <= '0;
         rsp_valid   <= 1'b0;
      end else begin
         if (cmd.enq) begin
            done_ff[e_idx] <= 1'b0;
            used_ff        <= used_ff + 1'b1;
         end
         if (cmd.mark) done_ff[p_idx] <= 1'b1;
         if (cmd.unlink_do) begin
            if (prev_ff == NIL) head_ff[run_lv_ff] <= next_ff[p_idx];
            if (tail_ff[run_lv_ff] == run_ff) tail_ff[run_lv_ff] <= prev_ff;
         end
         if (cmd.append) begin
            if (head_ff[ap_lv] == NIL || tail_ff[ap_lv] == NIL) head_ff[ap_lv] <= PW'(ap_e);
            tail_ff[ap_lv] <= PW'(ap_e);
         end
         if (cmd.search_init) run_ff <= NIL;
         if (cmd.select) run_ff <= p_ff;
         // Hold the result beat until taken
         if (cmd.out_write) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   // Walk pointers and per-event registers
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         hit_ff      <= run_valid && (run_task_ff == tid_ff);
         switched_ff <= 1'b0;
         status_ff   <= STS_OK;
         if (act_ff == ACT_ENQ) begin
            if (prio_bad) status_ff <= STS_BAD_PRIO;
            else if (full) status_ff <= STS_FULL;
         end
      end
      if (cmd.pass) switched_ff <= 1'b1;
      if (cmd.select) begin
         run_task_ff <= task_ff[p_idx];
         run_lv_ff   <= lv_ff;
      end
      if (cmd.unlink_init) begin
         p_ff     <= head_ff[run_lv_ff];
         prev_ff  <= NIL;
         steps_ff <= '0;
      end
      if (cmd.search_init || cmd.fin_init) begin
         lv_ff    <= '0;
         p_ff     <= head_ff[0];
         steps_ff <= '0;
      end
      if (cmd.step) begin
         prev_ff  <= p_ff;
         p_ff     <= next_ff[p_idx];
         steps_ff <= steps_ff + 1'b1;
      end
      if (cmd.next_level) begin
         lv_ff    <= lv_nx;
         p_ff     <= head_ff[lv_nx];
         steps_ff <= '0;
      end
      if (cmd.out_write) begin
         rsp_running_valid <= run_valid;
         rsp_running_task  <= run_valid ? run_task_ff : '0;
         rsp_switched      <= switched_ff;
         rsp_status        <= status_ff;
      end
   end

   // Checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= NIL)
      else $error("entry count past store size");

   a_run_stored: assert property (@(posedge clock) disable iff (reset)
      run_ff != NIL |-> run_ff < used_ff)
      else $error("running entry not in store");

   for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_chk
      a_head_tail: assert property (@(posedge clock) disable iff (reset)
         (head_ff[g] == NIL) == (tail_ff[g] == NIL))
         else $error("list head and tail disagree on empty");
   end

endmodule

`default_nettype wire

FILE: hw/rtl/multilevel_priority_round_robin_top.sv
// ----------------------------------------------------------------------------
// multilevel_priority_round_robin_top
// Multilevel priority scheduler with round robin per level; APB config port.
// ----------------------------------------------------------------------------
// Sequence: an enqueue without preemption, a rejected enqueue or an unused code
//   goes from EXEC to OUT, where the result beat is written. A finish walks the
//   levels in FIN and passes only if it named the running task. A pass runs PASS,
//   an unlink walk and APPEND if a task runs, then SINIT and SEARCH, then OUT.
// Flow: one event at a time, as a single list-walk pointer serves every event; the
//   next event is taken once the current one reaches the result register. A result
//   beat that is not taken holds the next event.
// Reset: synchronous; empties all lists, clears done bits and the running task,
//   sets num_levels to 3. Task payload stores are not cleared.
`default_nettype none

module multilevel_priority_round_robin_top
   import mlprr_pkg::*;
#(
   parameter int MAX_TASKS    = DEF_MAX_TASKS,
   parameter int MAX_LEVELS   = DEF_MAX_LEVELS,
   parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   mlprr_req_if.sink   req,
   mlprr_rsp_if.source rsp,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output      logic [31:0]              prdata,
   output      logic                     pready
);

   localparam int NW = $clog2(MAX_LEVELS + 1);

   logic [1:0]    num_levels_ff;
   logic [NW-1:0] n_levels;
   ctrl_cmd_type  cmd;
   dp_stat_type   stat;

   // Register write
   always_ff @(posedge clock) begin
      if (reset) begin
         num_levels_ff <= NUM_LEVELS_RESET;
      end else if (psel && penable && pwrite && paddr == CSR_NUM_LEVELS) begin
         num_levels_ff <= pwdata[1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_NUM_LEVELS) ? {30'd0, num_levels_ff} : 32'd0;

   // Clamp level count to 2 .. MAX_LEVELS
   always_comb begin
      if (num_levels_ff < 2'd2) n_levels = NW'(2);
      else if (32'(num_levels_ff) > MAX_LEVELS) n_levels = NW'(MAX_LEVELS);
      else n_levels = NW'(num_levels_ff);
   end

   mlprr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mlprr_dp #(
      .MAX_TASKS    (MAX_TASKS),
      .MAX_LEVELS   (MAX_LEVELS),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req.action),
      .req_task_id       (req.task_id),
      .req_priority      (req.priority_req),
      .n_levels          (n_levels),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_running_valid (rsp.running_valid),
      .rsp_running_task  (rsp.running_task),
      .rsp_switched      (rsp.switched),
      .rsp_status        (rsp.status)
   );

endmodule

`default_nettype wire
